>>> hdl/fds_pkg.sv
// ----------------------------------------------------------------------------
// fds_pkg
// Shared types, codes and helpers for the directory scanner.
// ----------------------------------------------------------------------------
package fds_pkg;

    localparam int ENTRIES_PER_SECTOR_DEF = 16;
    localparam int DOT_ENTRIES            = 2;
    localparam int OQ_DEPTH               = 4;
    localparam int OQ_PTR_W               = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W               = $clog2(OQ_DEPTH + 1);

    localparam logic [31:0] ROOT_CLUSTER  = 32'd2;
    localparam logic [31:0] END_OF_CHAIN  = 32'h0FFF_FFFF;
    localparam logic [7:0]  DELETED_MARK  = 8'hE5;
    localparam logic [7:0]  SPC_RESET     = 8'd8;

    // opcodes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_ENTRY = 2'd1;
    localparam logic [1:0] OP_FAT   = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_RECORD   = 2'd0;
    localparam logic [1:0] KIND_DIR_READ = 2'd1;
    localparam logic [1:0] KIND_FAT_READ = 2'd2;
    localparam logic [1:0] KIND_END      = 2'd3;

    // config register indexes
    localparam logic [1:0] CFG_ROOT_DIR_SECTOR     = 2'd0;
    localparam logic [1:0] CFG_SECTORS_PER_CLUSTER = 2'd1;
    localparam logic [1:0] CFG_FAT_BASE_SECTOR     = 2'd2;

    // extensions, byte 8 in bits 7:0
    localparam int NUM_EXT = 9;
    localparam logic [23:0] KNOWN_EXT [NUM_EXT] = '{
        24'h33504D,  // MP3
        24'h414D57,  // WMA
        24'h44494D,  // MID
        24'h564157,  // WAV
        24'h414C46,  // FLA
        24'h545854,  // TXT
        24'h4E4942,  // BIN
        24'h202020,  // three spaces
        24'h47474F   // OGG
    };

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_SCAN,
        MODE_WAIT_FAT
    } scan_mode_t;

    typedef struct packed {
        logic [31:0] root_dir_sector;
        logic [7:0]  sectors_per_cluster;
        logic [31:0] fat_base_sector;
    } cfg_t;

    typedef struct packed {
        scan_mode_t  mode;
        logic [7:0]  sector_in_cluster;
        logic [31:0] current_cluster;
        logic [31:0] current_sector;
        logic [15:0] accepted_count;
    } scan_state_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] name_base;
        logic [23:0] name_ext;
        logic [31:0] cluster;
        logic [31:0] entry_size;
        logic [31:0] fat_word;
        logic [31:0] folder_sector;
        logic [31:0] folder_cluster;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] request_sector;
        logic [6:0]  fat_word_index;
        logic [63:0] record_name;
        logic [23:0] record_ext;
        logic [31:0] record_cluster;
        logic [31:0] record_sector;
        logic [31:0] record_length;
        logic [15:0] record_number;
        logic        last;
    } result_t;

    function automatic logic ext_known(input logic [23:0] ext);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NUM_EXT; i++)
        begin
            if (ext == KNOWN_EXT[i])
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic result_t make_request(input logic [1:0] kind,
                                             input logic [31:0] sector,
                                             input logic [6:0] index);
        result_t r;
        r = '0;
        r.kind           = kind;
        r.request_sector = sector;
        r.fat_word_index = index;
        r.last           = 1'b1;
        return r;
    endfunction

endpackage

>>> hdl/fds_core.sv
// ----------------------------------------------------------------------------
// fds_core
// Per-item scan step: next scan state and up to two results.
// ----------------------------------------------------------------------------
module fds_core #(
    parameter int ENTRIES_PER_SECTOR = fds_pkg::ENTRIES_PER_SECTOR_DEF,
    parameter int SLOT_W             = $clog2(ENTRIES_PER_SECTOR)
) (
    input  fds_pkg::cfg_t        cfg,
    input  fds_pkg::scan_state_t state,
    input  logic [SLOT_W-1:0]    slot,
    input  fds_pkg::item_t       item,
    output fds_pkg::scan_state_t state_next,
    output logic [SLOT_W-1:0]    slot_next,
    output fds_pkg::result_t     res0,
    output fds_pkg::result_t     res1,
    output logic [1:0]           res_count
);
    import fds_pkg::*;

    logic [31:0] map_cluster;
    logic [31:0] map_offset;
    logic [31:0] map_product;
    logic [31:0] map_sector;

    // one shared cluster-to-sector mapper: FAT reply or entry cluster
    assign map_cluster = (item.opcode == OP_FAT) ? item.fat_word : item.cluster;
    assign map_offset  = map_cluster - ROOT_CLUSTER;
    assign map_product = map_offset * {24'd0, cfg.sectors_per_cluster};
    assign map_sector  = cfg.root_dir_sector + map_product;

    always_comb
    begin
        logic      take;
        logic      wrap;
        logic      is_root;
        logic [7:0] sic_inc;
        result_t   rec;
        result_t   req;

        state_next = state;
        slot_next  = slot;
        res0       = '0;
        res1       = '0;
        res_count  = 2'd0;
        take       = 1'b0;
        wrap       = 1'b0;
        is_root    = 1'b0;
        sic_inc    = state.sector_in_cluster + 8'd1;
        rec        = '0;
        req        = '0;

        case (item.opcode)
            OP_START:
            begin
                is_root                    = (item.folder_cluster == ROOT_CLUSTER);
                state_next.current_sector  = item.folder_sector;
                state_next.current_cluster = item.folder_cluster;
                state_next.sector_in_cluster = 8'd0;
                state_next.accepted_count  = 16'd0;
                state_next.mode            = MODE_SCAN;
                slot_next = is_root ? '0 : SLOT_W'(DOT_ENTRIES);
                res0      = make_request(KIND_DIR_READ, item.folder_sector, 7'd0);
                res_count = 2'd1;
            end
            OP_ENTRY:
            begin
                if (state.mode == MODE_SCAN)
                begin
                    if (item.name_base[31:0] == 32'd0)
                    begin
                        state_next.mode = MODE_IDLE;
                        res0      = make_request(KIND_END, 32'd0, 7'd0);
                        res_count = 2'd1;
                    end
                    else
                    begin
                        take = ((item.entry_size == 32'd0) || ext_known(item.name_ext))
                               && (item.name_base[7:0] != DELETED_MARK);
                        wrap = (slot == SLOT_W'(ENTRIES_PER_SECTOR - 1));

                        rec.kind           = KIND_RECORD;
                        rec.record_name    = item.name_base;
                        rec.record_ext     = item.name_ext;
                        rec.record_cluster = item.cluster;
                        rec.record_sector  = map_sector;
                        rec.record_length  = item.entry_size;
                        rec.record_number  = state.accepted_count;
                        rec.last           = !wrap;
                        if (take)
                        begin
                            state_next.accepted_count = state.accepted_count + 16'd1;
                        end

                        if (wrap)
                        begin
                            slot_next = '0;
                            state_next.sector_in_cluster = sic_inc;
                            if (sic_inc == cfg.sectors_per_cluster)
                            begin
                                state_next.mode = MODE_WAIT_FAT;
                                req = make_request(KIND_FAT_READ,
                                    cfg.fat_base_sector + {7'd0, state.current_cluster[31:7]},
                                    state.current_cluster[6:0]);
                            end
                            else
                            begin
                                state_next.current_sector = state.current_sector + 32'd1;
                                req = make_request(KIND_DIR_READ,
                                                   state.current_sector + 32'd1, 7'd0);
                            end
                        end
                        else
                        begin
                            slot_next = slot + SLOT_W'(1);
                        end

                        // record first, then the sector request
                        if (take)
                        begin
                            res0 = rec;
                            res1 = req;
                        end
                        else
                        begin
                            res0 = req;
                        end
                        res_count = {1'b0, take} + {1'b0, wrap};
                    end
                end
            end
            OP_FAT:
            begin
                if (state.mode == MODE_WAIT_FAT)
                begin
                    if (item.fat_word == END_OF_CHAIN)
                    begin
                        state_next.mode = MODE_IDLE;
                        res0 = make_request(KIND_END, 32'd0, 7'd0);
                    end
                    else
                    begin
                        state_next.current_cluster   = item.fat_word;
                        state_next.current_sector    = map_sector;
                        state_next.sector_in_cluster = 8'd0;
                        state_next.mode              = MODE_SCAN;
                        slot_next = '0;
                        res0 = make_request(KIND_DIR_READ, map_sector, 7'd0);
                    end
                    res_count = 2'd1;
                end
            end
            default:
            begin
                res_count = 2'd0;
            end
        endcase
    end

endmodule

>>> hdl/fds_out_queue.sv
// ----------------------------------------------------------------------------
// fds_out_queue
// Small result queue: pushes up to two words a cycle, pops one.
// ----------------------------------------------------------------------------
module fds_out_queue (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [1:0]                      push_count,
    input  fds_pkg::result_t                push0,
    input  fds_pkg::result_t                push1,
    input  logic                            pop,
    output fds_pkg::result_t                head,
    output logic [fds_pkg::OQ_CNT_W-1:0]    count,
    output logic                            room2
);
    import fds_pkg::*;

    result_t               entry_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]   wr_ptr_reg;
    logic [OQ_PTR_W-1:0]   wr_ptr_next;
    logic [OQ_PTR_W-1:0]   rd_ptr_reg;
    logic [OQ_PTR_W-1:0]   rd_ptr_next;
    logic [OQ_CNT_W-1:0]   count_reg;
    logic [OQ_CNT_W-1:0]   count_next;

    assign head  = entry_reg[rd_ptr_reg];
    assign count = count_reg;
    assign room2 = (count_reg <= OQ_CNT_W'(OQ_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + OQ_PTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + OQ_PTR_W'(pop);
        count_next  = count_reg + OQ_CNT_W'(push_count) - OQ_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2)
        begin
            entry_reg[wr_ptr_reg + OQ_PTR_W'(1)] <= push1;
        end
    end

endmodule

>>> hdl/fat32_directory_scanner.sv
// ----------------------------------------------------------------------------
// fat32_directory_scanner
// Walks a FAT32 folder: sector and FAT requests out, file records out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one word per item: a folder
//   start, a 32-byte directory entry, or a FAT word reply, chosen by opcode.
//   Output channel (out_valid/out_stall) returns result words: file records,
//   directory sector reads, FAT sector reads and scan end; "last" marks the
//   final word caused by one input word (an entry may cause two).
//   Config channel (cfg_valid/cfg_ready, always ready) writes the data area
//   base, sectors per cluster and FAT base; write only while idle.
// Timing: a taken word is held in the input register and evaluated there;
//   its results are written into the result queue, whose head is the output.
// Throughput: one input word per cycle while the queue has room for two
//   results; the output port delivers one result per cycle while out_stall
//   is low, and an entry that ends a sector and also yields a record gives
//   two results. The 4-deep result queue sets how far the two sides may drift
//   apart: the input register stalls when fewer than two slots are free.
// Reset: scan goes idle, queue empties, config returns to its reset values.
// Receiver stall: results wait in the queue; once it is nearly full the
//   held input word stalls the sender.
// ----------------------------------------------------------------------------
module fat32_directory_scanner #(
    parameter int ENTRIES_PER_SECTOR = fds_pkg::ENTRIES_PER_SECTOR_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [63:0] name_base,
    input  logic [23:0] name_ext,
    input  logic [15:0] cluster_high,
    input  logic [15:0] cluster_low,
    input  logic [31:0] entry_size,
    input  logic [31:0] fat_word,
    input  logic [31:0] folder_sector,
    input  logic [31:0] folder_cluster,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [31:0] request_sector,
    output logic [6:0]  fat_word_index,
    output logic [63:0] record_name,
    output logic [23:0] record_ext,
    output logic [31:0] record_cluster,
    output logic [31:0] record_sector,
    output logic [31:0] record_length,
    output logic [15:0] record_number,
    output logic        last
);
    import fds_pkg::*;

    localparam int SLOT_W = $clog2(ENTRIES_PER_SECTOR);

    // config registers
    cfg_t              cfg_reg;

    // input register
    logic              in_valid_reg;
    logic              in_valid_next;
    item_t             item_reg;
    logic              in_take;
    logic              consume;

    // scan state
    scan_state_t       state_reg;
    scan_state_t       state_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;

    // results
    result_t           res0;
    result_t           res1;
    logic [1:0]        res_count;
    logic [1:0]        push_count;
    result_t           head;
    logic [OQ_CNT_W-1:0] q_count;
    logic              q_room2;
    logic              pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.root_dir_sector     <= '0;
            cfg_reg.sectors_per_cluster <= SPC_RESET;
            cfg_reg.fat_base_sector     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ROOT_DIR_SECTOR:     cfg_reg.root_dir_sector     <= cfg_data;
                CFG_SECTORS_PER_CLUSTER: cfg_reg.sectors_per_cluster <= cfg_data[7:0];
                CFG_FAT_BASE_SECTOR:     cfg_reg.fat_base_sector     <= cfg_data;
                default:                 cfg_reg <= cfg_reg;
            endcase
        end
    end

    // held word moves on once the queue can take two results
    assign consume  = in_valid_reg && q_room2;
    assign in_stall = in_valid_reg && !q_room2;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (consume)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.opcode         <= opcode;
            item_reg.name_base      <= name_base;
            item_reg.name_ext       <= name_ext;
            item_reg.cluster        <= {cluster_high, cluster_low};
            item_reg.entry_size     <= entry_size;
            item_reg.fat_word       <= fat_word;
            item_reg.folder_sector  <= folder_sector;
            item_reg.folder_cluster <= folder_cluster;
        end
    end

    fds_core #(
        .ENTRIES_PER_SECTOR (ENTRIES_PER_SECTOR),
        .SLOT_W             (SLOT_W)
    ) u_core (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .slot       (slot_reg),
        .item       (item_reg),
        .state_next (state_next),
        .slot_next  (slot_next),
        .res0       (res0),
        .res1       (res1),
        .res_count  (res_count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode              <= MODE_IDLE;
            state_reg.sector_in_cluster <= '0;
            state_reg.current_cluster   <= '0;
            state_reg.current_sector    <= '0;
            state_reg.accepted_count    <= '0;
            slot_reg                    <= '0;
        end
        else if (consume)
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
        end
    end

    assign push_count = consume ? res_count : 2'd0;
    assign pop        = out_valid && !out_stall;

    fds_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push0      (res0),
        .push1      (res1),
        .pop        (pop),
        .head       (head),
        .count      (q_count),
        .room2      (q_room2)
    );

    assign out_valid      = (q_count != '0);
    assign kind           = head.kind;
    assign request_sector = head.request_sector;
    assign fat_word_index = head.fat_word_index;
    assign record_name    = head.record_name;
    assign record_ext     = head.record_ext;
    assign record_cluster = head.record_cluster;
    assign record_sector  = head.record_sector;
    assign record_length  = head.record_length;
    assign record_number  = head.record_number;
    assign last           = head.last;

`ifndef ASSERT_OFF
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= OQ_CNT_W'(OQ_DEPTH))
        else $error("result queue over depth");

    a_held_word_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !q_room2) |=> in_valid_reg)
        else $error("stalled input word lost");

    a_start_scans: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && item_reg.opcode == OP_START) |=> state_reg.mode == MODE_SCAN)
        else $error("start did not enter scan");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_END) |-> last)
        else $error("scan end without last");
`endif

endmodule
